@@ rtl/ubx_frame_receiver_macros.svh @@
// assertion helpers used by the checker file
`ifndef UBX_FRAME_RECEIVER_MACROS_SVH
`define UBX_FRAME_RECEIVER_MACROS_SVH

// same-cycle implication, sampled on the rising clock edge
`define UBX_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define UBX_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/ubx_pkg.sv @@
package ubx_pkg;

  localparam logic [7:0]  SYNC_ONE   = 8'hB5;
  localparam logic [7:0]  SYNC_TWO   = 8'h62;
  localparam logic [15:0] ID_ACK_NAK = 16'h0500;
  localparam logic [15:0] ID_ACK_ACK = 16'h0501;

  localparam int unsigned QUEUE_DEPTH = 2;

  // one received byte after classification
  typedef struct packed {
    logic       restart;
    logic       sync_one;
    logic       sync_two;
    logic [7:0] data;
  } item_t;

  typedef struct packed {
    logic [15:0] acked_id;
    logic [15:0] payload_index;
    logic [7:0]  payload_byte;
    logic        payload_valid;
    logic [15:0] msg_id;
    logic        checksum_error;
    logic        frame_done;
    logic [3:0]  parse_state;
  } result_t;

  function automatic logic is_ack(input logic [15:0] id);
    return (id == ID_ACK_NAK) || (id == ID_ACK_ACK);
  endfunction

endpackage

@@ rtl/ubx_frame_receiver.sv @@
// path: a byte's result passes through the queue write, then the parser register
// throughput: one byte per cycle while the result output is not stalled;
// the input keeps flowing while a result waits, until the two-entry queue fills
// reset: asynchronous, clears the parser to sync hunt with all sums and ids at zero,
// empties the queue and drops any pending result
module ubx_frame_receiver import ubx_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] rx_byte
  input  logic [0:0]  s_axis_tuser_i,   // [0] restart
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [3:0] parse_state, [19:4] msg_id, [27:20] payload_byte,
  // [43:28] payload_index, [59:44] acked_id, [63:60] zero
  output logic [63:0] m_axis_tdata_o,
  // [0] frame_done, [1] checksum_error, [2] payload_valid
  output logic [2:0]  m_axis_tuser_o
);

  logic    q_full, push, q_valid, pop;
  item_t   push_item, pop_item;
  result_t result;

  ubx_front u_front (
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i[0]),
    .q_full_i        (q_full),
    .push_o          (push),
    .push_item_o     (push_item)
  );

  ubx_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .full_o      (q_full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .pop_item_o  (pop_item)
  );

  ubx_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_item_i   (pop_item),
    .pop_o      (pop),
    .m_valid_o  (m_axis_tvalid_o),
    .m_ready_i  (m_axis_tready_i),
    .m_result_o (result)
  );

  assign m_axis_tdata_o = {4'h0, result.acked_id, result.payload_index, result.payload_byte,
                           result.msg_id, result.parse_state};
  assign m_axis_tuser_o = {result.payload_valid, result.checksum_error, result.frame_done};

endmodule

@@ rtl/ubx_front.sv @@
module ubx_front import ubx_pkg::*; (
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,
  input  logic       s_axis_tuser_i,
  input  logic       q_full_i,
  output logic       push_o,
  output item_t      push_item_o
);

  assign s_axis_tready_o = !q_full_i;
  assign push_o          = s_axis_tvalid_i && !q_full_i;

  // sync detection is done here so the parser only looks at flags
  always_comb begin
    push_item_o.restart  = s_axis_tuser_i;
    push_item_o.sync_one = (s_axis_tdata_i == SYNC_ONE);
    push_item_o.sync_two = (s_axis_tdata_i == SYNC_TWO);
    push_item_o.data     = s_axis_tdata_i;
  end

endmodule

@@ rtl/ubx_queue.sv @@
module ubx_queue import ubx_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t push_item_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  valid_o,
  output item_t pop_item_o
);

  localparam int unsigned PtrW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  item_t            mem_q [QUEUE_DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  count_q;

  assign full_o     = (count_q == CntW'(QUEUE_DEPTH));
  assign valid_o    = (count_q != '0);
  assign pop_item_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

@@ rtl/ubx_back.sv @@
module ubx_back import ubx_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    q_valid_i,
  input  item_t   q_item_i,
  output logic    pop_o,
  output logic    m_valid_o,
  input  logic    m_ready_i,
  output result_t m_result_o
);

  typedef enum logic [3:0] {
    PH_HUNT    = 4'd0,
    PH_SYNC2   = 4'd1,
    PH_CLASS   = 4'd2,
    PH_ID      = 4'd3,
    PH_LEN_LO  = 4'd4,
    PH_LEN_HI  = 4'd5,
    PH_PAYLOAD = 4'd6,
    PH_CK_A    = 4'd7,
    PH_CK_B    = 4'd8
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [7:0]  sum_a_q, sum_a_d, sum_b_q, sum_b_d;
  logic [15:0] msg_q, msg_d, left_q, left_d, pos_q, pos_d, ack_q, ack_d;
  logic        out_valid_q, out_valid_d;
  result_t     res_q, res_d, step_res;
  logic [7:0]  b, sa_add, sb_add;

  assign pop_o      = q_valid_i && (!out_valid_q || m_ready_i);
  assign m_valid_o  = out_valid_q;
  assign m_result_o = res_q;

  assign b      = q_item_i.data;
  assign sa_add = sum_a_q + b;
  assign sb_add = sum_b_q + sa_add;

  always_comb begin
    phase_d  = phase_q;
    sum_a_d  = sum_a_q;
    sum_b_d  = sum_b_q;
    msg_d    = msg_q;
    left_d   = left_q;
    pos_d    = pos_q;
    ack_d    = ack_q;
    step_res = '0;

    if (q_item_i.restart) begin
      phase_d = PH_HUNT;
    end else begin
      unique case (phase_q)
        PH_SYNC2: begin
          phase_d = q_item_i.sync_two ? PH_CLASS : PH_HUNT;
        end
        PH_CLASS: begin
          sum_a_d = b;
          sum_b_d = b;
          msg_d   = {b, 8'h00};
          phase_d = PH_ID;
        end
        PH_ID: begin
          sum_a_d = sa_add;
          sum_b_d = sb_add;
          msg_d   = {msg_q[15:8], b};
          phase_d = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          sum_a_d = sa_add;
          sum_b_d = sb_add;
          left_d  = {8'h00, b};
          phase_d = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          sum_a_d = sa_add;
          sum_b_d = sb_add;
          left_d  = {b, left_q[7:0]};
          pos_d   = '0;
          // empty payload skips straight to the checksum
          phase_d = (b == 8'h00 && left_q[7:0] == 8'h00) ? PH_CK_A : PH_PAYLOAD;
        end
        PH_PAYLOAD: begin
          sum_a_d = sa_add;
          sum_b_d = sb_add;
          if (is_ack(msg_q)) begin
            if (pos_q == 16'd0) begin
              ack_d = {b, ack_q[7:0]};
            end else if (pos_q == 16'd1) begin
              ack_d = {ack_q[15:8], b};
            end
          end else begin
            step_res.payload_valid = 1'b1;
            step_res.payload_byte  = b;
            step_res.payload_index = pos_q;
          end
          pos_d  = pos_q + 16'd1;
          left_d = left_q - 16'd1;
          if (left_q == 16'd1) begin
            phase_d = PH_CK_A;
          end
        end
        PH_CK_A: begin
          if (b == sum_a_q) begin
            phase_d = PH_CK_B;
          end else begin
            phase_d                 = PH_HUNT;
            step_res.checksum_error = 1'b1;
          end
        end
        PH_CK_B: begin
          phase_d = PH_HUNT;
          if (b == sum_b_q) begin
            step_res.frame_done = 1'b1;
            step_res.msg_id     = msg_q;
            if (is_ack(msg_q)) begin
              step_res.acked_id = ack_q;
            end
          end else begin
            step_res.checksum_error = 1'b1;
          end
        end
        default: begin
          phase_d = q_item_i.sync_one ? PH_SYNC2 : PH_HUNT;
        end
      endcase
    end
    step_res.parse_state = phase_d;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    res_d       = res_q;
    if (pop_o) begin
      out_valid_d = 1'b1;
      res_d       = step_res;
    end else if (m_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HUNT;
      sum_a_q     <= '0;
      sum_b_q     <= '0;
      msg_q       <= '0;
      left_q      <= '0;
      pos_q       <= '0;
      ack_q       <= '0;
      out_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      res_q       <= res_d;
      if (pop_o) begin
        phase_q <= phase_d;
        sum_a_q <= sum_a_d;
        sum_b_q <= sum_b_d;
        msg_q   <= msg_d;
        left_q  <= left_d;
        pos_q   <= pos_d;
        ack_q   <= ack_d;
      end
    end
  end

endmodule

@@ rtl/ubx_chk.sv @@
`include "ubx_frame_receiver_macros.svh"

module ubx_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [63:0] m_axis_tdata_o,
  input logic [2:0]  m_axis_tuser_o
);

  // a finished or dropped frame always leaves the parser hunting
  `UBX_ASSERT_NOW(a_done_hunts, m_axis_tvalid_o && (m_axis_tuser_o[0] || m_axis_tuser_o[1]), m_axis_tdata_o[3:0] == 4'd0, "frame end without return to hunt")

  // streamed payload only comes from the payload phase
  `UBX_ASSERT_NOW(a_payload_phase, m_axis_tvalid_o && m_axis_tuser_o[2], m_axis_tdata_o[3:0] == 4'd6 || m_axis_tdata_o[3:0] == 4'd7, "payload byte outside payload phase")

  // id fields are only carried on a good frame
  `UBX_ASSERT_NOW(a_ids_zero, m_axis_tvalid_o && !m_axis_tuser_o[0], m_axis_tdata_o[19:4] == 16'h0 && m_axis_tdata_o[59:44] == 16'h0, "id fields set without frame_done")

  // a stalled result transaction holds
  `UBX_ASSERT_NEXT(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o), "stalled result changed")

endmodule

bind ubx_frame_receiver ubx_chk u_chk (.*);

@@ tb/ubx_frame_receiver_test.sv @@
`timescale 1ns / 1ps

module ubx_frame_receiver_test;
  import ubx_pkg::*;

  localparam int unsigned IDLE_PCT    = 38;
  localparam int unsigned ITEM_TARGET = 650;
  localparam int unsigned HOLD_CYCLES = 150;

  // parser phases as shown on parse_state
  localparam logic [3:0] PH_HUNT    = 4'd0;
  localparam logic [3:0] PH_SYNC    = 4'd1;
  localparam logic [3:0] PH_CLASS   = 4'd2;
  localparam logic [3:0] PH_ID      = 4'd3;
  localparam logic [3:0] PH_LEN_LO  = 4'd4;
  localparam logic [3:0] PH_LEN_HI  = 4'd5;
  localparam logic [3:0] PH_PAYLOAD = 4'd6;
  localparam logic [3:0] PH_CK_A    = 4'd7;
  localparam logic [3:0] PH_CK_B    = 4'd8;

  typedef enum int {FRAME_GOOD, FRAME_BAD_CK_A, FRAME_BAD_CK_B, FRAME_CUT} frame_flaw_e;

  typedef struct packed {
    logic       restart;
    logic [7:0] data;
  } rx_item_t;

  class frame_scoreboard;
    logic [3:0]  phase;
    logic [7:0]  sum_a;
    logic [7:0]  sum_b;
    logic [15:0] cur_id;
    logic [15:0] bytes_left;
    logic [15:0] position;
    logic [15:0] ack_word;
    result_t     expected_results[$];
    int unsigned mismatches;

    function new();
      phase      = PH_HUNT;
      sum_a      = '0;
      sum_b      = '0;
      cur_id     = '0;
      bytes_left = '0;
      position   = '0;
      ack_word   = '0;
      mismatches = 0;
    endfunction

    function int unsigned pending();
      return expected_results.size();
    endfunction

    function void add_sum(logic [7:0] b);
      sum_a = sum_a + b;
      sum_b = sum_b + sum_a;
    endfunction

    function bit is_ack_id(logic [15:0] id);
      return (id == ID_ACK_NAK) || (id == ID_ACK_ACK);
    endfunction

    // advance the parser by one accepted byte and queue the result it gives
    function void note_byte(logic [7:0] b, logic restart);
      result_t r;
      r = '0;
      if (restart) begin
        phase = PH_HUNT;
      end else begin
        case (phase)
          PH_SYNC: phase = (b == SYNC_TWO) ? PH_CLASS : PH_HUNT;
          PH_CLASS: begin
            sum_a  = b;
            sum_b  = b;
            cur_id = {b, 8'h00};
            phase  = PH_ID;
          end
          PH_ID: begin
            add_sum(b);
            cur_id[7:0] = b;
            phase       = PH_LEN_LO;
          end
          PH_LEN_LO: begin
            add_sum(b);
            bytes_left = {8'h00, b};
            phase      = PH_LEN_HI;
          end
          PH_LEN_HI: begin
            add_sum(b);
            bytes_left[15:8] = b;
            position         = '0;
            phase            = (bytes_left == 0) ? PH_CK_A : PH_PAYLOAD;
          end
          PH_PAYLOAD: begin
            add_sum(b);
            if (is_ack_id(cur_id)) begin
              // only the first two ack bytes are kept, later ones just feed the sums
              if (position == 0) ack_word[15:8] = b;
              else if (position == 1) ack_word[7:0] = b;
            end else begin
              r.payload_valid = 1'b1;
              r.payload_byte  = b;
              r.payload_index = position;
            end
            position   = position + 1;
            bytes_left = bytes_left - 1;
            if (bytes_left == 0) phase = PH_CK_A;
          end
          PH_CK_A: begin
            if (b == sum_a) begin
              phase = PH_CK_B;
            end else begin
              phase            = PH_HUNT;
              r.checksum_error = 1'b1;
            end
          end
          PH_CK_B: begin
            phase = PH_HUNT;
            if (b == sum_b) begin
              r.frame_done = 1'b1;
              r.msg_id     = cur_id;
              if (is_ack_id(cur_id)) r.acked_id = ack_word;
            end else begin
              r.checksum_error = 1'b1;
            end
          end
          default: phase = (b == SYNC_ONE) ? PH_SYNC : PH_HUNT;
        endcase
      end
      r.parse_state = phase;
      expected_results.push_back(r);
    endfunction

    function void compare(string field, logic [15:0] want, logic [15:0] seen);
      if (want !== seen) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: %s mismatch, expected %h, got %h", $realtime, field, want, seen);
      end
    endfunction

    function void check_result(logic [63:0] tdata, logic [2:0] tuser);
      result_t want;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result with nothing pending, tdata %h tuser %b",
                   $realtime, tdata, tuser);
        return;
      end
      want = expected_results.pop_front();
      compare("parse_state",    16'(want.parse_state),    16'(tdata[3:0]));
      compare("msg_id",         want.msg_id,              tdata[19:4]);
      compare("payload_byte",   16'(want.payload_byte),   16'(tdata[27:20]));
      compare("payload_index",  want.payload_index,       tdata[43:28]);
      compare("acked_id",       want.acked_id,            tdata[59:44]);
      compare("tdata pad",      16'h0000,                 16'(tdata[63:60]));
      compare("frame_done",     16'(want.frame_done),     16'(tuser[0]));
      compare("checksum_error", 16'(want.checksum_error), 16'(tuser[1]));
      compare("payload_valid",  16'(want.payload_valid),  16'(tuser[2]));
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_tvalid;
  logic        s_axis_tready_o;
  logic [7:0]  s_tdata;
  logic [0:0]  s_tuser;
  logic        m_axis_tvalid_o;
  logic        m_tready;
  logic [63:0] m_axis_tdata_o;
  logic [2:0]  m_axis_tuser_o;

  frame_scoreboard board;
  rx_item_t        rx_queue[$];
  int unsigned     sent_total;
  logic            calm;
  logic            hold;

  ubx_frame_receiver DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // sink side: check every accepted result, stall at random or during the hold-off
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_tready)
      board.check_result(m_axis_tdata_o, m_axis_tuser_o);
    m_tready <= !hold && (calm || $urandom_range(99) >= IDLE_PCT);
  end

  task automatic send_byte(input logic [7:0] b, input logic restart);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tuser  <= restart;
    do @(posedge clk_i); while (!s_axis_tready_o);
    board.note_byte(b, restart);
    sent_total++;
    calm <= (sent_total >= 300) && (sent_total < 420);
  endtask

  task automatic flush_rx();
    rx_item_t it;
    while (rx_queue.size() != 0) begin
      it = rx_queue.pop_front();
      send_byte(it.data, it.restart);
    end
  endtask

  task automatic add_frame(input logic [15:0] id, input logic [15:0] len,
                           input frame_flaw_e flaw);
    logic [7:0]  body[$];
    logic [7:0]  ck_a;
    logic [7:0]  ck_b;
    int unsigned cut;
    body = {id[15:8], id[7:0], len[7:0], len[15:8]};
    repeat (len) body.push_back(8'($urandom));
    ck_a = '0;
    ck_b = '0;
    foreach (body[i]) begin
      ck_a = ck_a + body[i];
      ck_b = ck_b + ck_a;
    end
    if (flaw == FRAME_BAD_CK_A) ck_a ^= 8'($urandom_range(1, 255));
    if (flaw == FRAME_BAD_CK_B) ck_b ^= 8'($urandom_range(1, 255));
    body.push_front(SYNC_TWO);
    body.push_front(SYNC_ONE);
    body.push_back(ck_a);
    body.push_back(ck_b);
    cut = (flaw == FRAME_CUT) ? $urandom_range(1, body.size() - 1) : body.size();
    for (int i = 0; i < cut; i++) rx_queue.push_back('{1'b0, body[i]});
    // a truncated frame is abandoned by a restart
    if (flaw == FRAME_CUT) rx_queue.push_back('{1'b1, 8'($urandom)});
  endtask

  task automatic add_noise();
    if ($urandom_range(1)) rx_queue.push_back('{1'b0, SYNC_ONE});
    repeat ($urandom_range(1, 4))
      rx_queue.push_back('{($urandom_range(7) == 0), 8'($urandom)});
  endtask

  // long receiver hold-off while the source keeps offering bytes
  initial begin
    hold = 1'b0;
    wait (sent_total >= 150);
    @(posedge clk_i);
    hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold <= 1'b0;
  end

  initial begin
    #2_000_000;
    $display("ubx_frame_receiver_test: errors");
    $finish;
  end

  initial begin
    int unsigned roll;
    int unsigned frames;
    logic [15:0] id;
    board      = new();
    sent_total = 0;
    frames     = 0;
    calm       = 1'b0;
    rst_ni     = 1'b0;
    s_tvalid   = 1'b0;
    s_tdata    = '0;
    s_tuser    = '0;
    m_tready   = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // byte extremes, restart while hunting, repeated first sync byte,
    // empty payload, one-byte ack payload
    rx_queue = {'{1'b0, 8'h00}, '{1'b1, 8'hFF},
                '{1'b0, SYNC_ONE}, '{1'b0, SYNC_ONE}, '{1'b0, SYNC_TWO}};
    add_frame(16'hFF00, 16'd0, FRAME_GOOD);
    add_frame(ID_ACK_ACK, 16'd1, FRAME_GOOD);
    flush_rx();

    while (sent_total < ITEM_TARGET) begin
      roll = $urandom_range(99);
      if ($urandom_range(3) == 0)
        id = $urandom_range(1) ? ID_ACK_ACK : ID_ACK_NAK;
      else
        id = 16'($urandom);
      if (frames == 4) begin
        // one frame of 256 bytes or more so the high length byte is used
        add_frame(16'($urandom), 16'($urandom_range(256, 264)), FRAME_GOOD);
      end else if (roll < 70) begin
        add_frame(id, 16'($urandom_range(0, 12)), FRAME_GOOD);
      end else if (roll < 78) begin
        add_frame(id, 16'($urandom_range(0, 6)), FRAME_BAD_CK_A);
      end else if (roll < 86) begin
        add_frame(id, 16'($urandom_range(0, 6)), FRAME_BAD_CK_B);
      end else if (roll < 92) begin
        add_frame(id, 16'($urandom_range(0, 8)), FRAME_CUT);
      end else begin
        add_noise();
      end
      frames++;
      flush_rx();
    end
    s_tvalid <= 1'b0;

    while (board.pending() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("ubx_frame_receiver_test: clean");
    end else begin
      $display("ubx_frame_receiver_test: errors");
    end
    $finish;
  end

endmodule
